FILE: hw/rtl/g2l_pkg.sv
// Package: types, letter codes and the high-byte transliteration table.
`timescale 1ns / 1ps

package g2l_pkg;

    // ISO-8859-7 codes with special handling
    localparam logic [7:0] CAP_MU    = 8'd204;
    localparam logic [7:0] SML_MU    = 8'd236;
    localparam logic [7:0] CAP_NU    = 8'd205;
    localparam logic [7:0] SML_NU    = 8'd237;
    localparam logic [7:0] CAP_PI    = 8'd208;
    localparam logic [7:0] SML_PI    = 8'd240;
    localparam logic [7:0] CAP_TAU   = 8'd212;
    localparam logic [7:0] SML_TAU   = 8'd244;
    localparam logic [7:0] CAP_XI    = 8'd206;
    localparam logic [7:0] CAP_PSI   = 8'd216;
    localparam logic [7:0] CAP_THETA = 8'd200;
    localparam logic [7:0] CAP_OMEGA = 8'd217;

    localparam int unsigned MAX_OUT = 4;

    typedef enum logic [2:0] {
        HELD_NONE = 3'd0,
        HELD_CM   = 3'd1,
        HELD_SM   = 3'd2,
        HELD_CN   = 3'd3,
        HELD_SN   = 3'd4
    } t_held;

    // Up to three characters from one table entry, first in ch[0]
    typedef struct packed {
        logic [1:0]      len;
        logic [2:0][6:0] ch;
    } t_seq3;

    // Up to four characters caused by one item, first in ch[0]
    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][6:0] ch;
    } t_seq4;

    function automatic t_seq3 seq3(input logic [1:0] n, input logic [7:0] a,
                                   input logic [7:0] b, input logic [7:0] c);
        t_seq3 s;
        s.len   = n;
        s.ch[0] = a[6:0];
        s.ch[1] = b[6:0];
        s.ch[2] = c[6:0];
        return s;
    endfunction

    function automatic t_seq3 s1(input logic [7:0] a);
        return seq3(2'd1, a, 8'h00, 8'h00);
    endfunction

    function automatic t_seq3 s2(input logic [7:0] a, input logic [7:0] b);
        return seq3(2'd2, a, b, 8'h00);
    endfunction

    // Transliteration of a high byte; unmapped codes give an empty sequence
    function automatic t_seq3 high_map(input logic [7:0] b);
        t_seq3 s;
        case (b)
            8'd182:    s = s2("'", "A");
            8'd184:    s = s2("'", "E");
            8'd185:    s = s2("'", "H");
            8'd186:    s = s2("'", "I");
            8'd188:    s = s2("'", "O");
            8'd190:    s = s2("'", "Y");
            8'd191:    s = s2("'", "W");
            8'd192:    s = seq3(2'd3, "i", "\"", "'");
            8'd193:    s = s1("A");
            8'd194:    s = s1("V");
            8'd195:    s = s1("G");
            8'd196:    s = s1("D");
            8'd197:    s = s1("E");
            8'd198:    s = s1("Z");
            8'd199:    s = s1("H");
            CAP_THETA: s = s1("8");
            8'd201:    s = s1("I");
            8'd202:    s = s1("K");
            8'd203:    s = s1("L");
            CAP_MU:    s = s1("M");
            CAP_NU:    s = s1("N");
            CAP_XI:    s = s2("K", "S");
            8'd207:    s = s1("O");
            CAP_PI:    s = s1("P");
            8'd209:    s = s1("R");
            8'd211:    s = s1("S");
            CAP_TAU:   s = s1("T");
            8'd213:    s = s1("Y");
            8'd214:    s = s1("F");
            8'd215:    s = s1("X");
            CAP_PSI:   s = s2("P", "S");
            CAP_OMEGA: s = s1("W");
            8'd220:    s = s2("a", "'");
            8'd221:    s = s2("e", "'");
            8'd222:    s = s2("h", "'");
            8'd223:    s = s2("i", "'");
            8'd224:    s = seq3(2'd3, "y", "\"", "'");
            8'd225:    s = s1("a");
            8'd226:    s = s1("v");
            8'd227:    s = s1("g");
            8'd228:    s = s1("d");
            8'd229:    s = s1("e");
            8'd230:    s = s1("z");
            8'd231:    s = s1("h");
            8'd232:    s = s1("8");
            8'd233:    s = s1("i");
            8'd234:    s = s1("k");
            8'd235:    s = s1("l");
            SML_MU:    s = s1("m");
            SML_NU:    s = s1("n");
            8'd238:    s = s2("k", "s");
            8'd239:    s = s1("o");
            SML_PI:    s = s1("p");
            8'd241:    s = s1("r");
            8'd242:    s = s1("s");
            8'd243:    s = s1("s");
            SML_TAU:   s = s1("t");
            8'd245:    s = s1("y");
            8'd246:    s = s1("f");
            8'd247:    s = s1("x");
            8'd248:    s = s2("p", "s");
            8'd249:    s = s1("w");
            8'd250:    s = s2("i", "\"");
            8'd251:    s = s2("y", "\"");
            8'd252:    s = s2("o", "'");
            8'd253:    s = s2("y", "'");
            8'd254:    s = s2("w", "'");
            default:   s = seq3(2'd0, 8'h00, 8'h00, 8'h00);
        endcase
        return s;
    endfunction

    // Latin letter for a held mu or nu
    function automatic logic [6:0] held_char(input t_held h);
        logic [7:0] c;
        case (h)
            HELD_CM: c = "M";
            HELD_SM: c = "m";
            HELD_CN: c = "N";
            HELD_SN: c = "n";
            default: c = 8'h00;
        endcase
        return c[6:0];
    endfunction

endpackage

FILE: hw/rtl/g2l_in_if.sv
// Interface: input channel carrying one ISO-8859-7 byte or an end mark.
`timescale 1ns / 1ps

interface g2l_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

FILE: hw/rtl/g2l_out_if.sv
// Interface: output channel carrying one ASCII byte and its last flag.
`timescale 1ns / 1ps

interface g2l_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

FILE: hw/rtl/greek_to_latin_transliterator.sv
// Top level: ISO-8859-7 to Latin transliterator, one ASCII byte per output item.
`timescale 1ns / 1ps
//
//  channel | direction | handshake     | payload
//  --------+-----------+---------------+---------------------------------
//  i_in    | in        | valid / ready | in_byte[7:0], end_of_stream
//  o_out   | out       | valid / ready | out_byte[6:0], last
//
//  An input item is translated in the cycle it is accepted into zero to four
//  bytes, which land in a four-entry result register and leave one per cycle
//  while o_out is ready, in order through the single output port.
//  The next item is accepted in the same cycle the last pending byte is taken.
//  Reset (i_rst_n low, synchronous) drops pending bytes and any held mu or nu.
//  A stall on o_out holds the current byte and blocks i_in until it drains.

module greek_to_latin_transliterator
    import g2l_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    g2l_in_if.sink       i_in,
    g2l_out_if.source    o_out
);

    // Held mu or nu waiting for the next byte
    t_held       r_held;
    t_held       n_held;

    // Pending result bytes, r_buf[0] is on the output; r_cnt counts them
    logic [6:0]  r_buf [MAX_OUT];
    logic [2:0]  r_cnt;

    logic        in_fire;
    logic        out_fire;
    t_seq3       norm;
    logic        pre_vld;
    logic [6:0]  pre_ch;
    logic        hold_new;
    t_seq4       res;

    assign out_fire  = o_out.valid && o_out.ready;
    // Take a new item when the buffer is empty or its last byte leaves now
    assign i_in.ready = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && o_out.ready);
    assign in_fire   = i_in.valid && i_in.ready;

    assign o_out.valid    = (r_cnt != 3'd0);
    assign o_out.out_byte = r_buf[0];
    assign o_out.last     = (r_cnt == 3'd1);

    // Translate the incoming item against the held letter
    always_comb begin
        n_held   = HELD_NONE;
        pre_vld  = 1'b0;
        pre_ch   = held_char(r_held);
        hold_new = 1'b0;
        norm     = seq3(2'd0, 8'h00, 8'h00, 8'h00);

        if (i_in.end_of_stream) begin
            // Flush a held letter, nothing else
            pre_vld = (r_held != HELD_NONE);
        end else begin
            case (r_held)
                HELD_CM, HELD_SM: begin
                    pre_vld = 1'b1;
                    if (i_in.in_byte == CAP_PI || i_in.in_byte == SML_PI) begin
                        pre_ch   = (r_held == HELD_CM) ? 7'h42 : 7'h62;  // B / b
                        hold_new = 1'b1;
                    end
                end
                HELD_CN, HELD_SN: begin
                    pre_vld = 1'b1;
                    if (i_in.in_byte == CAP_TAU || i_in.in_byte == SML_TAU) begin
                        pre_ch   = (r_held == HELD_CN) ? 7'h44 : 7'h64;  // D / d
                        hold_new = 1'b1;
                    end
                end
                default: begin
                    pre_vld = 1'b0;
                end
            endcase

            // A completed pair swallows the byte; otherwise handle it normally
            if (!hold_new) begin
                if (!i_in.in_byte[7]) begin
                    norm = seq3(2'd1, i_in.in_byte, 8'h00, 8'h00);
                end else if (i_in.in_byte == CAP_MU) begin
                    n_held = HELD_CM;
                end else if (i_in.in_byte == SML_MU) begin
                    n_held = HELD_SM;
                end else if (i_in.in_byte == CAP_NU) begin
                    n_held = HELD_CN;
                end else if (i_in.in_byte == SML_NU) begin
                    n_held = HELD_SN;
                end else begin
                    norm = high_map(i_in.in_byte);
                end
            end
        end

        // Put the released letter ahead of the normal bytes
        if (pre_vld) begin
            res.len   = {1'b0, norm.len} + 3'd1;
            res.ch[0] = pre_ch;
            res.ch[1] = norm.ch[0];
            res.ch[2] = norm.ch[1];
            res.ch[3] = norm.ch[2];
        end else begin
            res.len   = {1'b0, norm.len};
            res.ch[0] = norm.ch[0];
            res.ch[1] = norm.ch[1];
            res.ch[2] = norm.ch[2];
            res.ch[3] = 7'h00;
        end
    end

    // Control state: held letter and pending count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= HELD_NONE;
            r_cnt  <= 3'd0;
        end else begin
            if (in_fire) begin
                r_held <= n_held;
                r_cnt  <= res.len;
            end else if (out_fire) begin
                r_cnt  <= r_cnt - 3'd1;
            end
        end
    end

    // Result bytes: load on accept, advance on each taken byte
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int k = 0; k < MAX_OUT; k++) begin
                r_buf[k] <= res.ch[k];
            end
        end else if (out_fire) begin
            for (int k = 0; k < MAX_OUT - 1; k++) begin
                r_buf[k] <= r_buf[k + 1];
            end
        end
    end

    // Pending count never exceeds the buffer depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("pending byte count out of range");

    // A new item only lands when no earlier byte would be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (r_cnt == 3'd0) || ((r_cnt == 3'd1) && out_fire))
        else $error("item accepted over pending bytes");

    // End of stream leaves nothing held
    a_eos_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.end_of_stream |=> r_held == HELD_NONE)
        else $error("letter still held after end of stream");

    // A byte that is not last is followed by another byte of the same item
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && !o_out.last |=> o_out.valid)
        else $error("output burst broken before last byte");

endmodule
